### hdl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants for the radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

	localparam int RADIX_W  = 7;
	localparam int DIGIT_W  = 7;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;

	// register word index (paddr[2])
	localparam logic REG_RADIX = 1'b0;

	// per-request control, classified at the front
	typedef struct packed {
		logic               err;
		logic [RADIX_W-1:0] radix;
	} rdc_ctl_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_READ,
		BK_SHOW
	} rdc_bk_state_t;

endpackage

`default_nettype wire

### hdl/radix_digit_converter_unit.sv
// Sequence: for each digit the bit-serial divider makes one pass, storing the
//   remainder on the digit stack; the digits are then popped out MSD first. A
//   flagged request goes straight to the output as a single error digit.
// Flow: one request at a time in the back end; the bit-serial divider sets
//   the pace.
// Reset: arst_n clears queue and sequencer at once; radix returns to 10.
// ----------------------------------------------------------------------------
// radix_digit_converter_unit
// Converts an unsigned value to digits in a configurable base, MSD first.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter_unit #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// APB register port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rdc_pkg::APB_AW-1:0]    paddr,
	input  wire logic [rdc_pkg::APB_DW-1:0]    pwdata,
	output logic [rdc_pkg::APB_DW-1:0]         prdata,
	output logic                               pready,
	// request channel
	input  wire logic                          value_valid,
	output logic                               value_ready,
	input  wire logic [VALUE_BITS-1:0]         value,
	// digit channel
	output logic                               digit_valid,
	input  wire logic                          digit_ready,
	output logic [rdc_pkg::DIGIT_W-1:0]        digit,
	output logic                               last,
	output logic                               error
);

	logic [rdc_pkg::RADIX_W-1:0] radix_q;
	logic                        reg_wr;
	logic                        job_valid, job_ready;
	logic [VALUE_BITS-1:0]       job_value;
	rdc_pkg::rdc_ctl_t           job_ctl;

	// Register file: radix only. Writes to other words are dropped.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && (paddr[2] == rdc_pkg::REG_RADIX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radix_q <= rdc_pkg::RADIX_RESET;
		else if (reg_wr)
			radix_q <= pwdata[rdc_pkg::RADIX_W-1:0];
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == rdc_pkg::REG_RADIX)
			prdata[rdc_pkg::RADIX_W-1:0] = radix_q;
	end

	// Front: takes requests, snapshots radix, flags bases below two.
	rdc_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (value_valid),
		.in_ready  (value_ready),
		.in_value  (value),
		.radix     (radix_q),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_value (job_value),
		.job_ctl   (job_ctl)
	);

	// Back: repeated division onto the digit stack, then pops to the output
	// register. A flagged request goes straight to the output as a single
	// error digit.
	rdc_back #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_value (job_value),
		.job_ctl   (job_ctl),
		.out_valid (digit_valid),
		.out_ready (digit_ready),
		.digit     (digit),
		.last      (last),
		.error     (error)
	);

	// An error digit is always a lone zero marked last.
	assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && error |-> last && (digit == '0))
		else $error("error digit not a lone zero");

	// Ordinary digits stay below the base (the user must change radix only when idle; the block does not enforce it).
	assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !error |-> ({1'b0, digit} < {1'b0, radix_q}))
		else $error("digit not below radix");

	// The queue only fills up through an accepted request.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(value_ready) |-> $past(value_valid))
		else $error("queue filled without a request");

endmodule

`default_nettype wire

### hdl/rdc_front.sv
// ----------------------------------------------------------------------------
// rdc_front
// Accepts requests, flags a bad radix, holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_front #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [VALUE_BITS-1:0]        in_value,
	input  wire logic [rdc_pkg::RADIX_W-1:0]  radix,
	output logic                              job_valid,
	input  wire logic                         job_ready,
	output logic [VALUE_BITS-1:0]             job_value,
	output rdc_pkg::rdc_ctl_t                 job_ctl
);

	logic [VALUE_BITS-1:0] val_q [2];
	rdc_pkg::rdc_ctl_t     ctl_q [2];
	logic                  wp_q, rp_q;
	logic [1:0]            cnt_q;
	logic                  push, pop;
	rdc_pkg::rdc_ctl_t     ctl_in;

	assign in_ready  = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;

	// classify on entry: radix snapshot and error flag
	always_comb begin
		ctl_in.radix = radix;
		ctl_in.err   = (radix < rdc_pkg::RADIX_MIN);
	end

	assign job_value = val_q[rp_q];
	assign job_ctl   = ctl_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			val_q[wp_q] <= in_value;
			ctl_q[wp_q] <= ctl_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

### hdl/rdc_back.sv
// ----------------------------------------------------------------------------
// rdc_back
// Bit-serial divider, digit stack and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_back #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          job_valid,
	output logic                               job_ready,
	input  wire logic [VALUE_BITS-1:0]         job_value,
	input  wire rdc_pkg::rdc_ctl_t             job_ctl,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [rdc_pkg::DIGIT_W-1:0]        digit,
	output logic                               last,
	output logic                               error
);

	localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int AW = $clog2(MAX_DIGITS);
	localparam int DW = $clog2(MAX_DIGITS + 1);
	localparam int RW = rdc_pkg::RADIX_W;

	rdc_pkg::rdc_bk_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] quo_q;
	logic [RW-1:0]         rem_q, radix_q;
	logic [CW-1:0]         cnt_q;
	logic [DW-1:0]         dep_q;
	logic [rdc_pkg::DIGIT_W-1:0] stack_mem [MAX_DIGITS];
	logic [rdc_pkg::DIGIT_W-1:0] digit_q;
	logic                  last_q, error_q;

	// one restoring-division step
	logic [RW:0]           r2;
	logic                  ge;
	logic [RW-1:0]         rem_n;
	logic [VALUE_BITS-1:0] quo_n;
	logic                  step_end;
	logic                  take;

	assign r2    = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge    = (r2 >= {1'b0, radix_q});
	assign rem_n = ge ? RW'(r2 - {1'b0, radix_q}) : r2[RW-1:0];
	assign quo_n = {quo_q[VALUE_BITS-2:0], ge};
	assign step_end = (cnt_q == CW'(VALUE_BITS - 1));

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		unique case (state_q)
			rdc_pkg::BK_IDLE: begin
				job_ready = 1'b1;
				if (job_valid)
					state_d = job_ctl.err ? rdc_pkg::BK_SHOW : rdc_pkg::BK_DIV;
			end
			rdc_pkg::BK_DIV: begin
				if (step_end && (quo_n == '0))
					state_d = rdc_pkg::BK_READ;
			end
			rdc_pkg::BK_READ: begin
				state_d = rdc_pkg::BK_SHOW;
			end
			rdc_pkg::BK_SHOW: begin
				if (out_ready)
					state_d = last_q ? rdc_pkg::BK_IDLE : rdc_pkg::BK_READ;
			end
			default: state_d = rdc_pkg::BK_IDLE;
		endcase
	end

	assign take = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rdc_pkg::BK_IDLE;
		else
			state_q <= state_d;
	end

	// divider and stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			dep_q <= '0;
		end else begin
			if (take) begin
				cnt_q <= '0;
				dep_q <= '0;
			end else if (state_q == rdc_pkg::BK_DIV) begin
				cnt_q <= step_end ? '0 : cnt_q + CW'(1);
				if (step_end && (dep_q != DW'(MAX_DIGITS)))
					dep_q <= dep_q + DW'(1);
			end else if (state_q == rdc_pkg::BK_READ) begin
				dep_q <= dep_q - DW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			quo_q   <= job_value;
			rem_q   <= '0;
			radix_q <= job_ctl.radix;
		end else if (state_q == rdc_pkg::BK_DIV) begin
			quo_q <= quo_n;
			rem_q <= step_end ? '0 : rem_n;
		end
	end

	// digit stack: write a remainder, read one on the way out
	always_ff @(posedge clk) begin
		if ((state_q == rdc_pkg::BK_DIV) && step_end && (dep_q != DW'(MAX_DIGITS)))
			stack_mem[dep_q[AW-1:0]] <= rem_n;
	end

	always_ff @(posedge clk) begin
		if (take && job_ctl.err) begin
			digit_q <= '0;
			last_q  <= 1'b1;
			error_q <= 1'b1;
		end else if (state_q == rdc_pkg::BK_READ) begin
			digit_q <= stack_mem[AW'(dep_q - DW'(1))];
			last_q  <= (dep_q == DW'(1));
			error_q <= 1'b0;
		end
	end

	assign out_valid = (state_q == rdc_pkg::BK_SHOW);
	assign digit     = digit_q;
	assign last      = last_q;
	assign error     = error_q;

endmodule

`default_nettype wire
